[rtl/core/jmsp_pkg.sv]
// Shared types, marker codes, result kinds and the zigzag table of the JPEG marker parser.
package jmsp_pkg;

    typedef enum logic [3:0]
    {
        PH_SOI1,
        PH_SOI2,
        PH_PAIR1,
        PH_PAIR2,
        PH_LENHI,
        PH_LENLO,
        PH_BODY,
        PH_SCAN,
        PH_DEAD
    } phase_t;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_DQT    = 8'hDB;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_DHT    = 8'hC4;
    localparam logic [7:0] MK_DRI    = 8'hDD;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_COM    = 8'hFE;
    localparam logic [3:0] MK_APP_HI = 4'hE;

    localparam logic [15:0] DRI_LENGTH = 16'd4;
    localparam logic [15:0] MIN_LENGTH = 16'd2;

    localparam logic [3:0] KIND_ERROR      = 4'd0;
    localparam logic [3:0] KIND_QUANT      = 4'd1;
    localparam logic [3:0] KIND_FRAME      = 4'd2;
    localparam logic [3:0] KIND_FRAME_COMP = 4'd3;
    localparam logic [3:0] KIND_HUFF_COUNT = 4'd4;
    localparam logic [3:0] KIND_HUFF_SYM   = 4'd5;
    localparam logic [3:0] KIND_RESTART    = 4'd6;
    localparam logic [3:0] KIND_SCAN_FIELD = 4'd7;
    localparam logic [3:0] KIND_SCAN_DATA  = 4'd8;

    // Huffman counts per table, and the last zigzag position
    localparam int unsigned HUFF_COUNTS = 16;
    localparam logic [5:0] ZZ_LAST = 6'd63;

    typedef struct packed
    {
        logic [3:0]  item_kind;
        logic [3:0]  table_class;
        logic [3:0]  table_id;
        logic [7:0]  slot;
        logic [11:0] index;
        logic [15:0] value;
        logic        segment_last;
    } result_t;

    typedef struct packed
    {
        logic    valid;
        result_t data;
    } result_msg_t;

    localparam logic [5:0] NATURAL_OF_ZZ [64] = '{
         6'd0,  6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

endpackage

[rtl/core/jmsp_byte_if.sv]
// Byte stream channel: one file byte and the start-of-file flag per transfer.
interface jmsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;

    modport source
    (
        output valid,
        output data_byte,
        output file_start,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  data_byte,
        input  file_start,
        output ready
    );
endinterface

[rtl/core/jmsp_item_if.sv]
// Result channel: one parsed header field or scan byte per transfer.
interface jmsp_item_if;
    logic        valid;
    logic        ready;
    logic [3:0]  item_kind;
    logic [3:0]  table_class;
    logic [3:0]  table_id;
    logic [7:0]  slot;
    logic [11:0] index;
    logic [15:0] value;
    logic        segment_last;

    modport source
    (
        output valid,
        output item_kind,
        output table_class,
        output table_id,
        output slot,
        output index,
        output value,
        output segment_last,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  item_kind,
        input  table_class,
        input  table_id,
        input  slot,
        input  index,
        input  value,
        input  segment_last,
        output ready
    );
endinterface

[rtl/core/jmsp_parser.sv]
// Parse state registers and the per-byte decode that yields at most one result.
module jmsp_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  file_start,
    output jmsp_pkg::result_msg_t result
);
    import jmsp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  marker_reg, marker_next;
    logic [7:0]  first_reg, first_next;
    logic [15:0] seglen_reg, seglen_next;
    logic [15:0] bpos_reg, bpos_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  nib_reg, nib_next;
    logic [7:0]  count_reg, count_next;
    logic [11:0] total_reg, total_next;
    logic [12:0] step_reg, step_next;
    logic [1:0]  field_reg, field_next;
    logic [8:0]  comp_reg, comp_next;

    phase_t      phase_cur;
    logic [15:0] p;
    logic [15:0] q;
    logic [15:0] r;
    logic [8:0]  n2;
    logic [16:0] bpos_inc;
    logic        last;
    logic [12:0] step_m1;
    logic [12:0] sym_n;
    logic [11:0] total_sum;
    logic [5:0]  zz;
    logic [15:0] length_now;
    logic        end_seg;
    result_msg_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SOI1;
            marker_reg <= '0;
            first_reg  <= '0;
            seglen_reg <= '0;
            bpos_reg   <= '0;
            hold_reg   <= '0;
            nib_reg    <= '0;
            count_reg  <= '0;
            total_reg  <= '0;
            step_reg   <= '0;
            field_reg  <= '0;
            comp_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            marker_reg <= marker_next;
            first_reg  <= first_next;
            seglen_reg <= seglen_next;
            bpos_reg   <= bpos_next;
            hold_reg   <= hold_next;
            nib_reg    <= nib_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            step_reg   <= step_next;
            field_reg  <= field_next;
            comp_reg   <= comp_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        marker_next = marker_reg;
        first_next  = first_reg;
        seglen_next = seglen_reg;
        bpos_next   = bpos_reg;
        hold_next   = hold_reg;
        nib_next    = nib_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        step_next   = step_reg;
        field_next  = field_reg;
        comp_next   = comp_reg;
        res         = '0;

        // a new file restarts the walk; every other field is rewritten before use
        phase_cur  = file_start ? PH_SOI1 : phase_reg;
        p          = bpos_reg - 16'd2;
        q          = p - 16'd1;
        n2         = {count_reg, 1'b0};
        r          = q - {7'd0, n2};
        bpos_inc   = {1'b0, bpos_reg} + 17'd1;
        last       = (bpos_inc >= {1'b0, seglen_reg});
        step_m1    = step_reg - 13'd1;
        sym_n      = step_reg - 13'd17;
        total_sum  = total_reg + {4'd0, data_byte};
        zz         = (nib_reg[7:4] == 4'd0) ? step_m1[5:0] : step_m1[6:1];
        length_now = {hold_reg, data_byte};
        end_seg    = 1'b0;

        res.data.table_class  = nib_reg[7:4];
        res.data.table_id     = nib_reg[3:0];
        res.data.value        = {8'd0, data_byte};
        res.data.segment_last = last;

        case (phase_cur)
            PH_SOI1:
            begin
                first_next = data_byte;
                phase_next = PH_SOI2;
            end
            PH_SOI2:
            begin
                if (first_reg != MK_PREFIX || data_byte != MK_SOI)
                begin
                    phase_next             = PH_DEAD;
                    res.valid              = 1'b1;
                    res.data               = '0;
                    res.data.item_kind     = KIND_ERROR;
                    res.data.value         = {8'd0, data_byte};
                    res.data.segment_last  = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAIR1;
                end
            end
            PH_PAIR1:
            begin
                first_next = data_byte;
                phase_next = PH_PAIR2;
            end
            PH_PAIR2:
            begin
                phase_next = PH_PAIR1;
                if (first_reg == MK_PREFIX &&
                    (data_byte[7:4] == MK_APP_HI || data_byte == MK_COM ||
                     data_byte == MK_DQT || data_byte == MK_SOF0 ||
                     data_byte == MK_DHT || data_byte == MK_DRI ||
                     data_byte == MK_SOS))
                begin
                    marker_next = data_byte;
                    phase_next  = PH_LENHI;
                end
            end
            PH_LENHI:
            begin
                hold_next  = data_byte;
                phase_next = PH_LENLO;
            end
            PH_LENLO:
            begin
                seglen_next = length_now;
                bpos_next   = 16'd2;
                step_next   = '0;
                nib_next    = '0;
                count_next  = '0;
                total_next  = '0;
                hold_next   = '0;
                field_next  = '0;
                comp_next   = '0;
                if (marker_reg == MK_DRI && length_now != DRI_LENGTH)
                begin
                    phase_next             = PH_DEAD;
                    res.valid              = 1'b1;
                    res.data               = '0;
                    res.data.item_kind     = KIND_ERROR;
                    res.data.value         = length_now;
                    res.data.segment_last  = 1'b1;
                end
                else if (length_now <= MIN_LENGTH)
                begin
                    end_seg = 1'b1;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                case (marker_reg)
                    MK_DQT:
                    begin
                        if (step_reg == 13'd0)
                        begin
                            nib_next  = data_byte;
                            step_next = 13'd1;
                        end
                        else if (nib_reg[7:4] != 4'd0 && !step_m1[0])
                        begin
                            hold_next = data_byte;
                            step_next = step_reg + 13'd1;
                        end
                        else
                        begin
                            step_next = (zz == ZZ_LAST) ? 13'd0 : step_reg + 13'd1;
                            res.valid          = 1'b1;
                            res.data.item_kind = KIND_QUANT;
                            res.data.index     = {6'd0, NATURAL_OF_ZZ[zz]};
                            if (nib_reg[7:4] != 4'd0)
                            begin
                                res.data.value = length_now;
                            end
                        end
                    end
                    MK_DHT:
                    begin
                        if (step_reg == 13'd0)
                        begin
                            nib_next   = data_byte;
                            total_next = '0;
                            step_next  = 13'd1;
                        end
                        else if (step_reg <= 13'(HUFF_COUNTS))
                        begin
                            total_next = total_sum;
                            step_next  = (step_reg == 13'(HUFF_COUNTS) && total_sum == 12'd0)
                                       ? 13'd0 : step_reg + 13'd1;
                            res.valid          = 1'b1;
                            res.data.item_kind = KIND_HUFF_COUNT;
                            res.data.index     = step_m1[11:0];
                        end
                        else
                        begin
                            step_next = (sym_n + 13'd1 >= {1'b0, total_reg})
                                      ? 13'd0 : step_reg + 13'd1;
                            res.valid          = 1'b1;
                            res.data.item_kind = KIND_HUFF_SYM;
                            res.data.index     = sym_n[11:0];
                        end
                    end
                    MK_SOF0:
                    begin
                        res.data.table_class = '0;
                        res.data.table_id    = '0;
                        res.data.item_kind   = KIND_FRAME;
                        case (p)
                            16'd0:
                            begin
                                res.valid = 1'b1;
                            end
                            16'd1, 16'd3:
                            begin
                                hold_next = data_byte;
                            end
                            16'd2:
                            begin
                                res.valid      = 1'b1;
                                res.data.index = 12'd1;
                                res.data.value = length_now;
                            end
                            16'd4:
                            begin
                                res.valid      = 1'b1;
                                res.data.index = 12'd2;
                                res.data.value = length_now;
                            end
                            16'd5:
                            begin
                                count_next     = data_byte;
                                res.valid      = 1'b1;
                                res.data.index = 12'd3;
                            end
                            default:
                            begin
                                // component fields come in threes; comp saturates past 255
                                if (comp_reg < {1'b0, count_reg})
                                begin
                                    res.valid          = 1'b1;
                                    res.data.item_kind = KIND_FRAME_COMP;
                                    res.data.slot      = comp_reg[7:0];
                                    res.data.index     = {10'd0, field_reg};
                                end
                                if (field_reg == 2'd2)
                                begin
                                    field_next = 2'd0;
                                    comp_next  = comp_reg[8] ? comp_reg : comp_reg + 9'd1;
                                end
                                else
                                begin
                                    field_next = field_reg + 2'd1;
                                end
                            end
                        endcase
                    end
                    MK_SOS:
                    begin
                        res.data.item_kind   = KIND_SCAN_FIELD;
                        res.data.table_class = '0;
                        res.data.table_id    = '0;
                        if (p == 16'd0)
                        begin
                            count_next = data_byte;
                            res.valid  = 1'b1;
                        end
                        else if (q < {7'd0, n2})
                        begin
                            res.valid     = 1'b1;
                            res.data.slot = q[8:1];
                            if (!q[0])
                            begin
                                res.data.index = 12'd1;
                            end
                            else
                            begin
                                res.data.index       = 12'd2;
                                res.data.table_class = data_byte[7:4];
                                res.data.table_id    = data_byte[3:0];
                            end
                        end
                        else if (r == 16'd0)
                        begin
                            res.valid      = 1'b1;
                            res.data.index = 12'd3;
                        end
                        else if (r == 16'd1)
                        begin
                            res.valid      = 1'b1;
                            res.data.index = 12'd4;
                        end
                        else if (r == 16'd2)
                        begin
                            res.valid            = 1'b1;
                            res.data.index       = 12'd5;
                            res.data.table_class = data_byte[7:4];
                            res.data.table_id    = data_byte[3:0];
                        end
                    end
                    MK_DRI:
                    begin
                        res.data.table_class = '0;
                        res.data.table_id    = '0;
                        if (p == 16'd0)
                        begin
                            hold_next = data_byte;
                        end
                        else if (p == 16'd1)
                        begin
                            res.valid          = 1'b1;
                            res.data.item_kind = KIND_RESTART;
                            res.data.value     = length_now;
                        end
                    end
                    default:
                    begin
                        // APPn and COM bodies are skipped
                    end
                endcase
                bpos_next = bpos_inc[15:0];
                if (bpos_inc[15:0] >= seglen_reg || bpos_inc[15:0] == 16'd0)
                begin
                    end_seg = 1'b1;
                end
            end
            PH_SCAN:
            begin
                res.valid              = 1'b1;
                res.data               = '0;
                res.data.item_kind     = KIND_SCAN_DATA;
                res.data.value         = {8'd0, data_byte};
            end
            default:
            begin
                // dead parse: ignore until the next file start
            end
        endcase

        if (end_seg)
        begin
            phase_next = (marker_reg == MK_SOS) ? PH_SCAN : PH_PAIR1;
        end
    end

    assign result = res;

endmodule

[rtl/core/jmsp_out_stage.sv]
// Result register with a skid entry so a new byte can be taken while a result waits.
module jmsp_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  jmsp_pkg::result_msg_t result,
    output logic                  room,
    jmsp_item_if.source           items
);
    import jmsp_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;
    logic    fill;

    assign pop  = main_valid_reg && items.ready;
    assign fill = push && result.valid;
    assign room = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (fill)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (fill)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_reg <= result.data;
            end
            else
            begin
                main_reg <= result.data;
            end
        end
    end

    assign items.valid        = main_valid_reg;
    assign items.item_kind    = main_reg.item_kind;
    assign items.table_class  = main_reg.table_class;
    assign items.table_id     = main_reg.table_id;
    assign items.slot         = main_reg.slot;
    assign items.index        = main_reg.index;
    assign items.value        = main_reg.value;
    assign items.segment_last = main_reg.segment_last;

endmodule

[rtl/core/jpeg_marker_segment_parser_core.sv]
// Top level of the JPEG marker segment parser: byte stream in, header fields and scan data out.
//
//  channel  dir  payload                                             handshake
//  bytes    in   data_byte[7:0], file_start                          valid/ready
//  items    out  item_kind, table_class, table_id, slot, index,     valid/ready
//                value[15:0], segment_last
//
// One byte per cycle while ready is high: each transfer updates the parse state and fills
// the result register, or the skid entry if that register still waits, in the same cycle.
// Reset puts the parser in the wait-for-start-of-image phase with no results held.
// A result register plus one skid entry absorb a stall; ready drops only when both
// hold a result, and returns the cycle after the sink takes one.
module jpeg_marker_segment_parser_core
(
    input  logic       clk,
    input  logic       rst_n,
    jmsp_byte_if.sink  bytes,
    jmsp_item_if.source items
);
    import jmsp_pkg::*;

    result_msg_t result;
    logic        room;
    logic        accept;

    assign bytes.ready = room;
    assign accept      = bytes.valid && room;

    jmsp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (bytes.data_byte),
        .file_start (bytes.file_start),
        .result     (result)
    );

    jmsp_out_stage u_out_stage
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .result (result),
        .room   (room),
        .items  (items)
    );

endmodule
